FILE: hw/rtl/ray_box_nearest_hit_top_defines.svh
`ifndef RAY_BOX_NEAREST_HIT_TOP_DEFINES_SVH
`define RAY_BOX_NEAREST_HIT_TOP_DEFINES_SVH

// Same-cycle implication, quiet while reset is applied
`define RBNH_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, quiet while reset is applied
`define RBNH_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/rbnh_pkg.sv
package rbnh_pkg;

    localparam int COORD_W = 32;
    localparam int HALF_W  = 31;
    localparam int ID_W    = 10;
    localparam int OFS_W   = 35;
    localparam int NUM_W   = 51;
    localparam int MAG_W   = 51;
    localparam int QUO_W   = 52;
    localparam int T_W     = 53;
    localparam int PROD_W  = 64;
    localparam int AXES    = 3;

    localparam logic [2:0] CFG_ORIGIN_X = 3'd0;
    localparam logic [2:0] CFG_ORIGIN_Y = 3'd1;
    localparam logic [2:0] CFG_ORIGIN_Z = 3'd2;
    localparam logic [2:0] CFG_DIR_X    = 3'd3;
    localparam logic [2:0] CFG_DIR_Y    = 3'd4;
    localparam logic [2:0] CFG_DIR_Z    = 3'd5;

    localparam logic signed [T_W-1:0] T_NEG   = -(53'sd1 <<< 51);
    localparam logic signed [T_W-1:0] T_POS   = (53'sd1 <<< 51);
    localparam logic signed [T_W-1:0] SAT_MAX = 53'sd2147483647;
    localparam logic signed [T_W-1:0] SAT_MIN = -53'sd2147483648;

    typedef struct packed {
        logic                         elig;
        logic                         last;
        logic [ID_W-1:0]              id;
        logic [AXES-1:0]              miss;
        logic [AXES-1:0][OFS_W-1:0]   rlo;
        logic [AXES-1:0][OFS_W-1:0]   rhi;
    } box_req_t;

    typedef struct packed {
        logic                          box_hit;
        logic [COORD_W-1:0]            entry_distance;
        logic                          any_hit;
        logic [COORD_W-1:0]            nearest_distance;
        logic [ID_W-1:0]               nearest_id;
        logic [AXES-1:0][COORD_W-1:0]  point;
        logic                          cast_done;
    } result_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_AXIS,
        B_DIV_LO,
        B_DIV_HI,
        B_UPDATE,
        B_MUL,
        B_ADD,
        B_OUT
    } back_state_t;

    function automatic logic [COORD_W-1:0] sat32(input logic signed [T_W-1:0] v);
        logic [COORD_W-1:0] r;
        if (v > SAT_MAX)
            r = SAT_MAX[COORD_W-1:0];
        else if (v < SAT_MIN)
            r = SAT_MIN[COORD_W-1:0];
        else
            r = v[COORD_W-1:0];
        return r;
    endfunction

endpackage

FILE: hw/rtl/rbnh_front.sv
module rbnh_front #(
    parameter int BOX_ID_LIMIT = 1024
) (
    input  logic                                            in_valid,
    output logic                                            in_ready,
    input  logic [rbnh_pkg::COORD_W-1:0]                    center_x,
    input  logic [rbnh_pkg::COORD_W-1:0]                    center_y,
    input  logic [rbnh_pkg::COORD_W-1:0]                    center_z,
    input  logic [rbnh_pkg::HALF_W-1:0]                     half_x,
    input  logic [rbnh_pkg::HALF_W-1:0]                     half_y,
    input  logic [rbnh_pkg::HALF_W-1:0]                     half_z,
    input  logic [rbnh_pkg::ID_W-1:0]                       box_id,
    input  logic                                            eligible,
    input  logic                                            last_box,
    input  logic [rbnh_pkg::AXES-1:0][rbnh_pkg::COORD_W-1:0] origin,
    input  logic [rbnh_pkg::AXES-1:0][rbnh_pkg::COORD_W-1:0] dir,
    input  logic                                            q_full,
    output logic                                            q_push,
    output rbnh_pkg::box_req_t                              q_data
);
    import rbnh_pkg::*;

    logic [AXES-1:0][COORD_W-1:0] ctr;
    logic [AXES-1:0][HALF_W-1:0]  hlf;
    logic signed [COORD_W+1:0]    lo [AXES];
    logic signed [COORD_W+1:0]    hi [AXES];
    logic signed [OFS_W-1:0]      rlo [AXES];
    logic signed [OFS_W-1:0]      rhi [AXES];

    assign ctr = {center_z, center_y, center_x};
    assign hlf = {half_z, half_y, half_x};

    assign in_ready = !q_full;
    assign q_push   = in_valid && !q_full;

    always_comb
    begin
        q_data      = '0;
        q_data.elig = eligible && (32'(box_id) < BOX_ID_LIMIT);
        q_data.last = last_box;
        q_data.id   = box_id;
        for (int i = 0; i < AXES; i++)
        begin
            lo[i]  = 34'($signed(ctr[i])) - $signed({3'b000, hlf[i]});
            hi[i]  = 34'($signed(ctr[i])) + $signed({3'b000, hlf[i]});
            rlo[i] = 35'(lo[i]) - 35'($signed(origin[i]));
            rhi[i] = 35'(hi[i]) - 35'($signed(origin[i]));
            q_data.rlo[i] = rlo[i];
            q_data.rhi[i] = rhi[i];
            // flat slab: ray either runs inside it or misses the box outright
            q_data.miss[i] = (dir[i] == '0) && ((rlo[i] > 35'sd0) || (rhi[i] < 35'sd0));
        end
    end

endmodule

FILE: hw/rtl/rbnh_queue.sv
module rbnh_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  rbnh_pkg::box_req_t wdata,
    output logic               full,
    input  logic               pop,
    output logic               rvalid,
    output rbnh_pkg::box_req_t rdata
);
    import rbnh_pkg::*;
    `include "ray_box_nearest_hit_top_defines.svh"

    box_req_t   mem_reg [2];
    logic       wptr_reg, wptr_next;
    logic       rptr_reg, rptr_next;
    logic [1:0] count_reg, count_next;

    assign full   = (count_reg == 2'd2);
    assign rvalid = (count_reg != 2'd0);
    assign rdata  = mem_reg[rptr_reg];

    always_comb
    begin
        wptr_next  = wptr_reg ^ push;
        rptr_next  = rptr_reg ^ pop;
        count_next = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wptr_reg] <= wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    `RBNH_ASSERT_NOW(a_no_overflow, push, !full, "request pushed into full queue")
    `RBNH_ASSERT_NOW(a_no_underflow, pop, rvalid, "request popped from empty queue")
    `RBNH_ASSERT_NOW(a_count_range, 1'b1, count_reg != 2'd3, "queue count out of range")

endmodule

FILE: hw/rtl/rbnh_div.sv
module rbnh_div (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic signed [rbnh_pkg::NUM_W-1:0]  num,
    input  logic signed [rbnh_pkg::COORD_W-1:0] den,
    output logic                               busy,
    output logic                               done,
    output logic signed [rbnh_pkg::QUO_W-1:0]  quo
);
    import rbnh_pkg::*;

    logic [MAG_W-1:0]   q_reg, q_next;
    logic [COORD_W-1:0] rem_reg, rem_next;
    logic [COORD_W-1:0] dmag_reg;
    logic               neg_reg;
    logic [5:0]         cnt_reg, cnt_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [COORD_W:0]   rem_sh;
    logic               ge;

    assign busy = busy_reg;
    assign done = done_reg;
    assign quo  = neg_reg ? -$signed({1'b0, q_reg}) : $signed({1'b0, q_reg});

    // one quotient bit a cycle, restoring
    always_comb
    begin
        rem_sh    = {rem_reg, q_reg[MAG_W-1]};
        ge        = rem_sh >= {1'b0, dmag_reg};
        rem_next  = ge ? 32'(rem_sh - {1'b0, dmag_reg}) : rem_sh[COORD_W-1:0];
        q_next    = {q_reg[MAG_W-2:0], ge};
        cnt_next  = cnt_reg - 6'd1;
        busy_next = busy_reg && (cnt_reg != 6'd1);
        done_next = busy_reg && (cnt_reg == 6'd1);
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg    <= num[NUM_W-1] ? 51'(-num) : 51'(num);
            dmag_reg <= den[COORD_W-1] ? 32'(-den) : 32'(den);
            neg_reg  <= num[NUM_W-1] ^ den[COORD_W-1];
            rem_reg  <= '0;
        end
        else if (busy_reg)
        begin
            q_reg   <= q_next;
            rem_reg <= rem_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= 6'(MAG_W);
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= busy_reg ? cnt_next : cnt_reg;
        end
    end

endmodule

FILE: hw/rtl/rbnh_back.sv
module rbnh_back (
    input  logic                                            clk,
    input  logic                                            rst_n,
    input  logic [rbnh_pkg::AXES-1:0][rbnh_pkg::COORD_W-1:0] origin,
    input  logic [rbnh_pkg::AXES-1:0][rbnh_pkg::COORD_W-1:0] dir,
    input  logic                                            q_valid,
    input  rbnh_pkg::box_req_t                              q_data,
    output logic                                            q_pop,
    output logic                                            out_valid,
    input  logic                                            out_ready,
    output rbnh_pkg::result_t                               res
);
    import rbnh_pkg::*;
    `include "ray_box_nearest_hit_top_defines.svh"

    back_state_t             st_reg, st_next;
    box_req_t                item_reg;
    logic [1:0]              axis_reg;
    logic signed [T_W-1:0]   tmin_reg, tmax_reg;
    logic signed [QUO_W-1:0] ea_reg;
    logic                    miss_reg;
    logic                    hit_reg;
    logic [COORD_W-1:0]      entry_reg;
    logic                    best_valid_reg;
    logic [COORD_W-1:0]      best_dist_reg;
    logic [ID_W-1:0]         best_id_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic [AXES-1:0][COORD_W-1:0] pt_reg;
    result_t                 res_reg;
    logic                    res_valid_reg;

    logic                    axis_end;
    logic                    dir_zero;
    logic                    div_start;
    logic                    div_busy;
    logic                    div_done;
    logic signed [QUO_W-1:0] div_quo;
    logic signed [NUM_W-1:0] div_num;
    logic signed [QUO_W-1:0] q_e, q_l;
    logic                    hit_now;
    logic [COORD_W-1:0]      entry_now;
    logic                    take;
    logic                    load_out;
    logic signed [T_W-1:0]   pt_sum;

    rbnh_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   ($signed(dir[axis_reg])),
        .busy  (div_busy),
        .done  (div_done),
        .quo   (div_quo)
    );

    always_comb
    begin
        axis_end  = !item_reg.elig || miss_reg || (axis_reg == 2'd3) || (tmin_reg > tmax_reg);
        dir_zero  = (dir[axis_reg] == '0);
        q_e       = (div_quo < ea_reg) ? div_quo : ea_reg;
        q_l       = (div_quo < ea_reg) ? ea_reg : div_quo;
        hit_now   = item_reg.elig && !miss_reg && !(tmin_reg > tmax_reg);
        entry_now = hit_now ? sat32(tmin_reg) : '0;
        take      = hit_now && (!best_valid_reg || ($signed(entry_now) < $signed(best_dist_reg)));
        pt_sum    = 53'($signed(prod_reg[PROD_W-1:16])) + 53'($signed(origin[axis_reg]));
    end

    // next state
    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            B_IDLE:   if (q_valid) st_next = B_AXIS;
            B_AXIS:
            begin
                if (axis_end)
                    st_next = B_UPDATE;
                else if (!dir_zero)
                    st_next = B_DIV_LO;
            end
            B_DIV_LO: if (div_done) st_next = B_DIV_HI;
            B_DIV_HI: if (div_done) st_next = B_AXIS;
            B_UPDATE: st_next = B_MUL;
            B_MUL:    st_next = B_ADD;
            B_ADD:    st_next = (axis_reg == 2'd2) ? B_OUT : B_MUL;
            B_OUT:    if (!res_valid_reg || out_ready) st_next = B_IDLE;
            default:  st_next = B_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        q_pop     = 1'b0;
        div_start = 1'b0;
        div_num   = $signed({item_reg.rlo[axis_reg], 16'h0000});
        load_out  = 1'b0;
        case (st_reg)
            B_IDLE:   q_pop = q_valid;
            B_AXIS:   div_start = !axis_end && !dir_zero;
            B_DIV_LO:
            begin
                div_start = div_done;
                div_num   = $signed({item_reg.rhi[axis_reg], 16'h0000});
            end
            B_OUT:    load_out = !res_valid_reg || out_ready;
            default:  q_pop = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        case (st_reg)
            B_IDLE:
            begin
                item_reg <= q_data;
                axis_reg <= 2'd0;
                tmin_reg <= T_NEG;
                tmax_reg <= T_POS;
                miss_reg <= 1'b0;
            end
            B_AXIS:
            begin
                if (!axis_end && dir_zero)
                begin
                    miss_reg <= item_reg.miss[axis_reg];
                    axis_reg <= axis_reg + 2'd1;
                end
            end
            B_DIV_LO: if (div_done) ea_reg <= div_quo;
            B_DIV_HI:
            begin
                if (div_done)
                begin
                    if (53'(q_e) > tmin_reg) tmin_reg <= 53'(q_e);
                    if (53'(q_l) < tmax_reg) tmax_reg <= 53'(q_l);
                    axis_reg <= axis_reg + 2'd1;
                end
            end
            B_UPDATE:
            begin
                hit_reg   <= hit_now;
                entry_reg <= entry_now;
                axis_reg  <= 2'd0;
            end
            B_MUL:    prod_reg <= $signed(best_dist_reg) * $signed(dir[axis_reg]);
            B_ADD:
            begin
                pt_reg[axis_reg] <= best_valid_reg ? sat32(pt_sum) : '0;
                axis_reg <= axis_reg + 2'd1;
            end
            default:  axis_reg <= axis_reg;
        endcase
        if (load_out)
        begin
            res_reg.box_hit          <= hit_reg;
            res_reg.entry_distance   <= entry_reg;
            res_reg.any_hit          <= best_valid_reg;
            res_reg.nearest_distance <= best_dist_reg;
            res_reg.nearest_id       <= best_id_reg;
            res_reg.point            <= pt_reg;
            res_reg.cast_done        <= item_reg.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg         <= B_IDLE;
            best_valid_reg <= 1'b0;
            best_dist_reg  <= '0;
            best_id_reg    <= '0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            if ((st_reg == B_UPDATE) && take)
            begin
                best_valid_reg <= 1'b1;
                best_dist_reg  <= entry_now;
                best_id_reg    <= item_reg.id;
            end
            // drop the best at the close of a cast
            if (load_out && item_reg.last)
            begin
                best_valid_reg <= 1'b0;
                best_dist_reg  <= '0;
                best_id_reg    <= '0;
            end
            if (load_out)
                res_valid_reg <= 1'b1;
            else if (out_ready)
                res_valid_reg <= 1'b0;
        end
    end

    assign out_valid = res_valid_reg;
    assign res       = res_reg;

    `RBNH_ASSERT_NOW(a_div_idle_on_start, div_start, !div_busy, "divider restarted while busy")
    `RBNH_ASSERT_NOW(a_best_clear, !best_valid_reg, (best_dist_reg == '0) && (best_id_reg == '0), "stale best without valid")
    `RBNH_ASSERT_NEXT(a_cast_reset, load_out && item_reg.last, !best_valid_reg, "best kept past end of cast")

endmodule

FILE: hw/rtl/ray_box_nearest_hit_top.sv
// A box that is skipped or missed on a flat axis may need no division, while one whose
// three axes all need both slab quotients takes six divisions in the shared divider.
// The divider yields one quotient bit per cycle; boxes are handled one at a time,
// so a new box is not started until the previous one has been output.
// A two-entry request queue lets the input side run ahead of the slab engine.
// Reset (rst_n low, asynchronous) loads origin 0 and direction +x, clears the best hit.
module ray_box_nearest_hit_top #(
    parameter int BOX_ID_LIMIT = 1024
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [2:0]                    cfg_index,
    input  logic [rbnh_pkg::COORD_W-1:0]  cfg_wdata,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [rbnh_pkg::COORD_W-1:0]  center_x,
    input  logic [rbnh_pkg::COORD_W-1:0]  center_y,
    input  logic [rbnh_pkg::COORD_W-1:0]  center_z,
    input  logic [rbnh_pkg::HALF_W-1:0]   half_x,
    input  logic [rbnh_pkg::HALF_W-1:0]   half_y,
    input  logic [rbnh_pkg::HALF_W-1:0]   half_z,
    input  logic [rbnh_pkg::ID_W-1:0]     box_id,
    input  logic                          eligible,
    input  logic                          last_box,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          box_hit,
    output logic [rbnh_pkg::COORD_W-1:0]  entry_distance,
    output logic                          any_hit,
    output logic [rbnh_pkg::COORD_W-1:0]  nearest_distance,
    output logic [rbnh_pkg::ID_W-1:0]     nearest_id,
    output logic [rbnh_pkg::COORD_W-1:0]  point_x,
    output logic [rbnh_pkg::COORD_W-1:0]  point_y,
    output logic [rbnh_pkg::COORD_W-1:0]  point_z,
    output logic                          cast_done
);
    import rbnh_pkg::*;

    logic [AXES-1:0][COORD_W-1:0] origin_reg;
    logic [AXES-1:0][COORD_W-1:0] dir_reg;
    logic     q_full;
    logic     q_push;
    logic     q_pop;
    logic     q_valid;
    box_req_t q_wdata;
    box_req_t q_rdata;
    result_t  res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_reg <= '0;
            dir_reg    <= {32'd0, 32'd0, 32'd65536};
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ORIGIN_X: origin_reg[0] <= cfg_wdata;
                CFG_ORIGIN_Y: origin_reg[1] <= cfg_wdata;
                CFG_ORIGIN_Z: origin_reg[2] <= cfg_wdata;
                CFG_DIR_X:    dir_reg[0]    <= cfg_wdata;
                CFG_DIR_Y:    dir_reg[1]    <= cfg_wdata;
                CFG_DIR_Z:    dir_reg[2]    <= cfg_wdata;
                default:      dir_reg       <= dir_reg;
            endcase
        end
    end

    rbnh_front #(
        .BOX_ID_LIMIT (BOX_ID_LIMIT)
    ) u_front (
        .in_valid (in_valid),
        .in_ready (in_ready),
        .center_x (center_x),
        .center_y (center_y),
        .center_z (center_z),
        .half_x   (half_x),
        .half_y   (half_y),
        .half_z   (half_z),
        .box_id   (box_id),
        .eligible (eligible),
        .last_box (last_box),
        .origin   (origin_reg),
        .dir      (dir_reg),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_data   (q_wdata)
    );

    rbnh_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (q_push),
        .wdata  (q_wdata),
        .full   (q_full),
        .pop    (q_pop),
        .rvalid (q_valid),
        .rdata  (q_rdata)
    );

    rbnh_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .origin    (origin_reg),
        .dir       (dir_reg),
        .q_valid   (q_valid),
        .q_data    (q_rdata),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .res       (res)
    );

    assign box_hit          = res.box_hit;
    assign entry_distance   = res.entry_distance;
    assign any_hit          = res.any_hit;
    assign nearest_distance = res.nearest_distance;
    assign nearest_id       = res.nearest_id;
    assign point_x          = res.point[0];
    assign point_y          = res.point[1];
    assign point_z          = res.point[2];
    assign cast_done        = res.cast_done;

endmodule
